// ----- hw/rtl/ctes_pkg.sv -----
package ctes_pkg;

  localparam int OUT_WIDTH = 48;

  localparam int YEAR_BASE      = 1900;
  localparam int ERA_YEARS      = 400;
  localparam int ERA_DAYS       = 146097;
  // Days from 0000-03-01 to 1970-01-01, plus one for the first day of the month.
  localparam int EPOCH_SHIFT    = 719469;
  localparam int DAY_SECONDS    = 86400;
  localparam int HOUR_SECONDS   = 3600;
  localparam int MINUTE_SECONDS = 60;

  localparam int DOY_WIDTH = 9;
  localparam int DOE_WIDTH = 18;

  // Day of the March-based year on which a month begins, month 0 being January.
  function automatic logic [DOY_WIDTH-1:0] month_day_offset(input logic [3:0] month);
    logic [DOY_WIDTH-1:0] offset;
    unique case (month)
      4'd0:    offset = 9'd306;
      4'd1:    offset = 9'd337;
      4'd2:    offset = 9'd0;
      4'd3:    offset = 9'd31;
      4'd4:    offset = 9'd61;
      4'd5:    offset = 9'd92;
      4'd6:    offset = 9'd122;
      4'd7:    offset = 9'd153;
      4'd8:    offset = 9'd184;
      4'd9:    offset = 9'd214;
      4'd10:   offset = 9'd245;
      4'd11:   offset = 9'd275;
      default: offset = 9'd0;
    endcase
    return offset;
  endfunction

endpackage

// ----- hw/rtl/ctes_in_if.sv -----
interface ctes_in_if #(
  parameter int FIELD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] years_since_1900;
  logic signed [FIELD_WIDTH-1:0] month_index;
  logic signed [FIELD_WIDTH-1:0] day_of_month;
  logic signed [FIELD_WIDTH-1:0] hour_value;
  logic signed [FIELD_WIDTH-1:0] minute_value;
  logic signed [FIELD_WIDTH-1:0] second_value;

  modport source (
    output valid, years_since_1900, month_index, day_of_month,
           hour_value, minute_value, second_value,
    input  ready
  );

  modport sink (
    input  valid, years_since_1900, month_index, day_of_month,
           hour_value, minute_value, second_value,
    output ready
  );
endinterface

// ----- hw/rtl/ctes_out_if.sv -----
interface ctes_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ctes_pkg::OUT_WIDTH-1:0] epoch_seconds;
  logic                                  overflow;

  modport source (
    output valid, epoch_seconds, overflow,
    input  ready
  );

  modport sink (
    input  valid, epoch_seconds, overflow,
    output ready
  );
endinterface

// ----- hw/rtl/ctes_cfg_if.sv -----
interface ctes_cfg_if;
  logic valid;
  logic ready;
  logic narrow_time_mode;

  modport source (
    output valid, narrow_time_mode,
    input  ready
  );

  modport sink (
    input  valid, narrow_time_mode,
    output ready
  );
endinterface

// ----- hw/rtl/civil_time_to_epoch_seconds.sv -----
// Nine register stages, each with its own valid bit, carry an item in order to the output;
// throughput is one item per cycle while the output is ready.
// A stalled output holds only the stages that are full, so bubbles close up.
// The widest multiply is the days-times-86400 product, split into two partial products.
// Reset (synchronous, active high) empties every stage and clears the narrow mode.
module civil_time_to_epoch_seconds #(
  parameter int FIELD_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  ctes_cfg_if.sink  cfg,
  ctes_in_if.sink   item,
  ctes_out_if.source result
);
  import ctes_pkg::*;

  localparam int NS = 9;
  localparam int FW = FIELD_WIDTH;

  // Floor division of the month by 12, done on a biased unsigned value.
  localparam int UW12 = FW + 1;
  localparam int M12W = UW12 - 3;
  localparam logic [M12W-1:0] M12    = M12W'((64'd1 << UW12) / 64'd12);
  localparam logic [UW12-1:0] BIAS12 = UW12'(64'd12 << (FW - 4));

  // Floor division of the year by 400, also biased.
  localparam int YW  = ((FW > 12) ? FW : 12) + 2;
  localparam int UW4 = YW + 1;
  localparam int M4W = UW4 - 8;
  localparam logic [M4W-1:0] M400 = M4W'((64'd1 << UW4) / 64'd400);
  localparam logic [UW4-1:0] K3   = UW4'(longint'(YEAR_BASE) - (longint'(1) << (FW - 4))
                                         + (longint'(ERA_YEARS) << (YW - 8)));

  localparam int EW  = M4W + 1;
  localparam logic signed [EW-1:0] ERA_BIAS = EW'(longint'(1) << (YW - 8));
  localparam int EPW = EW + 19;
  localparam int DW  = EPW + 1;
  localparam int DHW = DW - 24;
  localparam int HW  = FW + 14;
  localparam int SW  = ((DW + 18) > 49) ? (DW + 18) : 49;

  localparam logic signed [18:0] ERA_DAYS_S = 19'(ERA_DAYS);
  localparam logic signed [17:0] DAY_SEC_S  = 18'(DAY_SECONDS);
  localparam logic        [16:0] DAY_SEC_U  = 17'(DAY_SECONDS);
  localparam logic signed [12:0] HOUR_SEC_S = 13'(HOUR_SECONDS);
  localparam logic signed [7:0]  MIN_SEC_S  = 8'(MINUTE_SECONDS);
  localparam logic [UW4-1:0]     ERA_YEARS_W = UW4'(ERA_YEARS);
  localparam logic [DW-1:0]      EPOCH_SHIFT_W = DW'(EPOCH_SHIFT);

  logic narrow_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      narrow_mode <= cfg.narrow_time_mode;
    end
  end

  assign cfg.ready = 1'b1;

  // Per-stage valid bits and advance enables.
  logic [NS:1]   v;
  logic [NS+1:1] adv;

  always_comb begin
    adv[NS+1] = result.ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign item.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= item.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: bias the month and multiply by the reciprocal of 12.
  logic [UW12-1:0]          u12_c;
  logic [UW12+M12W-1:0]     p12_c;
  logic signed [FW+12:0]    hp_c;
  logic signed [FW+7:0]     mp_c;

  assign u12_c = UW12'(item.month_index) + BIAS12;
  assign p12_c = u12_c * M12;
  assign hp_c  = item.hour_value * HOUR_SEC_S;
  assign mp_c  = item.minute_value * MIN_SEC_S;

  logic [UW12-1:0]       s1_u12;
  logic [M12W-1:0]       s1_q;
  logic signed [FW-1:0]  s1_year;
  logic signed [FW-1:0]  s1_day;
  logic signed [FW+12:0] s1_hp;
  logic signed [FW+7:0]  s1_mp;
  logic signed [FW-1:0]  s1_sec;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_u12  <= u12_c;
      s1_q    <= p12_c[UW12+M12W-1:UW12];
      s1_year <= item.years_since_1900;
      s1_day  <= item.day_of_month;
      s1_hp   <= hp_c;
      s1_mp   <= mp_c;
      s1_sec  <= item.second_value;
    end
  end

  // Stage 2: correct the quotient estimate; sum the time of day.
  logic [UW12-1:0] r12_full_c;
  logic [4:0]      r12_c;
  logic            corr12_c;

  assign r12_full_c = s1_u12 - ((UW12'(s1_q) << 3) + (UW12'(s1_q) << 2));
  assign r12_c      = r12_full_c[4:0];
  assign corr12_c   = r12_c >= 5'd12;

  logic [M12W-1:0]      s2_q;
  logic [3:0]           s2_month;
  logic signed [FW-1:0] s2_year;
  logic signed [FW-1:0] s2_day;
  logic signed [HW-1:0] s2_hms;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_q     <= s1_q + M12W'(corr12_c);
      s2_month <= corr12_c ? 4'(r12_c - 5'd12) : r12_c[3:0];
      s2_year  <= s1_year;
      s2_day   <= s1_day;
      s2_hms   <= HW'(s1_hp) + HW'(s1_mp) + HW'(s1_sec);
    end
  end

  // Stage 3: carried year, moved back one for January and February, biased for /400.
  logic jan_feb_c;

  assign jan_feb_c = s2_month < 4'd2;

  logic [UW4-1:0]       s3_u400;
  logic [DOY_WIDTH-1:0] s3_doy;
  logic signed [FW-1:0] s3_day;
  logic signed [HW-1:0] s3_hms;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_u400 <= UW4'(s2_year) + UW4'(s2_q) + K3 - UW4'(jan_feb_c);
      s3_doy  <= month_day_offset(s2_month);
      s3_day  <= s2_day;
      s3_hms  <= s2_hms;
    end
  end

  // Stage 4: reciprocal multiply for the era.
  logic [UW4+M4W-1:0] p400_c;

  assign p400_c = s3_u400 * M400;

  logic [UW4-1:0]       s4_u400;
  logic [M4W-1:0]       s4_q;
  logic [DOY_WIDTH-1:0] s4_doy;
  logic signed [FW-1:0] s4_day;
  logic signed [HW-1:0] s4_hms;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_u400 <= s3_u400;
      s4_q    <= p400_c[UW4+M4W-1:UW4];
      s4_doy  <= s3_doy;
      s4_day  <= s3_day;
      s4_hms  <= s3_hms;
    end
  end

  // Stage 5: correct the era estimate; the remainder is the year of the era.
  logic [UW4-1:0] r400_full_c;
  logic [9:0]     r400_c;
  logic           corr400_c;

  assign r400_full_c = s4_u400 - ((UW4'(s4_q) << 8) + (UW4'(s4_q) << 7) + (UW4'(s4_q) << 4));
  assign r400_c      = r400_full_c[9:0];
  assign corr400_c   = r400_c >= 10'(ERA_YEARS_W);

  logic [M4W-1:0]       s5_era;
  logic [8:0]           s5_yoe;
  logic [DOY_WIDTH-1:0] s5_doy;
  logic signed [FW-1:0] s5_day;
  logic signed [HW-1:0] s5_hms;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_era <= s4_q + M4W'(corr400_c);
      s5_yoe <= corr400_c ? 9'(r400_c - 10'(ERA_YEARS_W)) : r400_c[8:0];
      s5_doy <= s4_doy;
      s5_day <= s4_day;
      s5_hms <= s4_hms;
    end
  end

  // Stage 6: days of the whole eras and day of the era.
  logic signed [EW-1:0]  era_c;
  logic signed [EPW-1:0] eprod_c;
  logic [1:0]            cent_c;
  logic [DOE_WIDTH-1:0]  doe_c;

  assign era_c   = $signed({1'b0, s5_era}) - ERA_BIAS;
  assign eprod_c = era_c * ERA_DAYS_S;
  assign cent_c  = {1'b0, s5_yoe >= 9'd100} + {1'b0, s5_yoe >= 9'd200}
                 + {1'b0, s5_yoe >= 9'd300};
  assign doe_c   = DOE_WIDTH'(s5_yoe) * DOE_WIDTH'(365) + DOE_WIDTH'(s5_yoe >> 2)
                 - DOE_WIDTH'(cent_c) + DOE_WIDTH'(s5_doy);

  logic signed [EPW-1:0] s6_eprod;
  logic [DOE_WIDTH-1:0]  s6_doe;
  logic signed [FW-1:0]  s6_day;
  logic signed [HW-1:0]  s6_hms;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_eprod <= eprod_c;
      s6_doe   <= doe_c;
      s6_day   <= s5_day;
      s6_hms   <= s5_hms;
    end
  end

  // Stage 7: days since the epoch.
  logic signed [DW-1:0] s7_days;
  logic signed [HW-1:0] s7_hms;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_days <= DW'(s6_eprod) + DW'(s6_doe) + DW'(s6_day) - EPOCH_SHIFT_W;
      s7_hms  <= s6_hms;
    end
  end

  // Stage 8: days times 86400, split into two partial products.
  logic [23:0]           dl_c;
  logic signed [DHW-1:0] dh_c;
  logic [40:0]           pl_c;
  logic signed [DHW+17:0] ph_c;

  assign dl_c = s7_days[23:0];
  assign dh_c = s7_days[DW-1:24];
  assign pl_c = dl_c * DAY_SEC_U;
  assign ph_c = dh_c * DAY_SEC_S;

  logic [40:0]            s8_pl;
  logic signed [DHW+17:0] s8_ph;
  logic signed [HW-1:0]   s8_hms;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_pl  <= pl_c;
      s8_ph  <= ph_c;
      s8_hms <= s7_hms;
    end
  end

  // Stage 9: final sum and the signed 32-bit range check.
  logic signed [SW-1:0] secs_c;
  logic                 ovf_c;

  assign secs_c = (SW'(s8_ph) << 24) + SW'(s8_pl) + SW'(s8_hms);
  assign ovf_c  = narrow_mode && !((&secs_c[SW-1:31]) || !(|secs_c[SW-1:31]));

  logic signed [OUT_WIDTH-1:0] epoch_q;
  logic                        overflow_q;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      epoch_q    <= ovf_c ? '1 : secs_c[OUT_WIDTH-1:0];
      overflow_q <= ovf_c;
    end
  end

  assign result.valid         = v[NS];
  assign result.epoch_seconds = epoch_q;
  assign result.overflow      = overflow_q;

  // The input side only stalls when every stage holds an item.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (&v))
    else $error("input stalled while the pipeline has a bubble");

  // A full first stage that cannot move keeps its item.
  a_first_stage_holds: assert property (@(posedge clk) disable iff (rst)
    v[1] && !adv[1] |=> v[1])
    else $error("item dropped from the first stage during a stall");

  // An overflowing result carries the all-ones error value.
  a_overflow_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |-> (result.epoch_seconds == '1))
    else $error("overflow result without the all-ones value");

endmodule
